/* src/mfa_pkg.sv */
// ----------------------------------------------------------------------------
// mfa_pkg
// Shared widths, command codes and helpers for the Montgomery field ALU.
// ----------------------------------------------------------------------------
package mfa_pkg;

  // field and radix widths
  localparam int FIELD_BITS   = 131;
  localparam int RADIX_BITS   = 160;
  localparam int LIMB_BITS    = 32;
  localparam int NUM_LIMBS    = RADIX_BITS / LIMB_BITS;
  localparam int PROD_BITS    = 2 * RADIX_BITS;
  localparam int TH_BITS      = 2 * FIELD_BITS - RADIX_BITS;
  localparam int DEF_MOD_BITS = 131;

  // configuration register indexes
  localparam logic [2:0] REG_MOD_LO  = 3'd0;
  localparam logic [2:0] REG_MOD_MID = 3'd1;
  localparam logic [2:0] REG_MOD_HI  = 3'd2;
  localparam logic [2:0] REG_INV_LO  = 3'd3;
  localparam logic [2:0] REG_INV_MID = 3'd4;
  localparam logic [2:0] REG_INV_HI  = 3'd5;

  // commands
  typedef enum logic [2:0] {
    CMD_ADD = 3'd0,
    CMD_SUB = 3'd1,
    CMD_NEG = 3'd2,
    CMD_MUL = 3'd3,
    CMD_SQR = 3'd4
  } cmd_t;

  // mask of the operand bits below n
  function automatic logic [FIELD_BITS-1:0] field_mask(input int unsigned n);
    logic [FIELD_BITS-1:0] m;
    m = '0;
    for (int i = 0; i < FIELD_BITS; i++) begin
      m[i] = (i < n);
    end
    return m;
  endfunction

endpackage

/* src/montgomery_field_alu_core.sv */
// Throughput: one operation per cycle while not stalled; three 3-stage limb
// multipliers in series (product, reduction factor, reduction) set the depth.
// The whole pipeline holds while the output waits to be taken.
// Reset (rst, synchronous) clears all valid bits and the modulus and inverse registers.
// ----------------------------------------------------------------------------
// montgomery_field_alu_core
// Pipelined modular add, subtract, negate and Montgomery multiply / square.
// ----------------------------------------------------------------------------
module montgomery_field_alu_core #(
  parameter int MODULUS_BITS = mfa_pkg::DEF_MOD_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  cmd,
  input  logic [63:0] a_lo,
  input  logic [63:0] a_mid,
  input  logic [2:0]  a_hi,
  input  logic [63:0] b_lo,
  input  logic [63:0] b_mid,
  input  logic [2:0]  b_hi,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] z_lo,
  output logic [63:0] z_mid,
  output logic [2:0]  z_hi
);

  localparam int FB = mfa_pkg::FIELD_BITS;
  localparam int RB = mfa_pkg::RADIX_BITS;
  localparam int PB = mfa_pkg::PROD_BITS;
  localparam int TB = mfa_pkg::TH_BITS;
  localparam int NSTG = 12;
  localparam logic [FB-1:0] OP_MASK = mfa_pkg::field_mask(MODULUS_BITS);

  logic          en;
  logic [NSTG-1:0] vld;
  logic [FB-1:0] mod_r;
  logic [RB-1:0] inv_r;
  logic [FB-1:0] p;

  mfa_pkg::cmd_t cmd0;
  logic [FB-1:0] a0, b0;
  logic [FB:0]   add_s, sub_d;
  logic [FB-1:0] lin_next;

  mfa_pkg::cmd_t cmd_q [1:10];
  logic [FB-1:0] lin_q [1:10];
  logic [TB-1:0] th_q [4:9];
  logic          c_q [4:9];

  logic [PB-1:0] t_prod, m_prod, u_prod;
  logic [RB-1:0] y1;
  logic [RB:0]   r;
  logic [RB:0]   r_red;
  logic [FB-1:0] z_next, z;

  // pipeline advances unless the output holds an untaken result
  assign en       = !vld[NSTG-1] || out_ready;
  assign in_ready = en;
  assign out_valid = vld[NSTG-1];
  assign p = mod_r & OP_MASK;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mod_r <= '0;
      inv_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mfa_pkg::REG_MOD_LO:  mod_r[63:0]    <= cfg_data;
        mfa_pkg::REG_MOD_MID: mod_r[127:64]  <= cfg_data;
        mfa_pkg::REG_MOD_HI:  mod_r[130:128] <= cfg_data[2:0];
        mfa_pkg::REG_INV_LO:  inv_r[63:0]    <= cfg_data;
        mfa_pkg::REG_INV_MID: inv_r[127:64]  <= cfg_data;
        mfa_pkg::REG_INV_HI:  inv_r[159:128] <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NSTG-2:0], in_valid};
    end
  end

  // stage 0: input register
  always_ff @(posedge clk) begin
    if (en) begin
      cmd0 <= mfa_pkg::cmd_t'(cmd);
      a0   <= {a_hi, a_mid, a_lo} & OP_MASK;
      b0   <= {b_hi, b_mid, b_lo} & OP_MASK;
    end
  end

  // add, subtract and negate
  always_comb begin
    add_s = {1'b0, a0} + {1'b0, b0};
    sub_d = {1'b0, a0} - {1'b0, b0};
    unique case (cmd0)
      mfa_pkg::CMD_ADD: lin_next = (add_s >= {1'b0, p}) ? FB'(add_s - {1'b0, p})
                                                       : add_s[FB-1:0];
      mfa_pkg::CMD_SUB: lin_next = sub_d[FB] ? sub_d[FB-1:0] + p : sub_d[FB-1:0];
      mfa_pkg::CMD_NEG: lin_next = (a0 == '0) ? '0 : p - a0;
      default:          lin_next = '0;
    endcase
  end

  // side data alongside the multipliers
  always_ff @(posedge clk) begin
    if (en) begin
      cmd_q[1] <= cmd0;
      lin_q[1] <= lin_next;
      for (int s = 2; s <= 10; s++) begin
        cmd_q[s] <= cmd_q[s-1];
        lin_q[s] <= lin_q[s-1];
      end
      th_q[4] <= t_prod[RB +: TB];
      c_q[4]  <= |t_prod[RB-1:0];
      for (int s = 5; s <= 9; s++) begin
        th_q[s] <= th_q[s-1];
        c_q[s]  <= c_q[s-1];
      end
    end
  end

  // product t = a * b (or a * a)
  assign y1 = RB'((cmd0 == mfa_pkg::CMD_SQR) ? a0 : b0);

  mfa_mul #(.LowOnly(1'b0)) u_mul_t (
    .clk (clk), .en (en), .x (RB'(a0)), .y (y1), .prod (t_prod)
  );

  // m = (t mod R) * k mod R
  mfa_mul #(.LowOnly(1'b1)) u_mul_m (
    .clk (clk), .en (en), .x (t_prod[RB-1:0]), .y (inv_r), .prod (m_prod)
  );

  // u = m * p
  mfa_mul #(.LowOnly(1'b0)) u_mul_u (
    .clk (clk), .en (en), .x (m_prod[RB-1:0]), .y (RB'(p)), .prod (u_prod)
  );

  // stage 10: high halves plus reduction carry
  always_ff @(posedge clk) begin
    if (en) begin
      r <= (RB+1)'(th_q[9]) + (RB+1)'(u_prod[PB-1:RB]) + (RB+1)'(c_q[9]);
    end
  end

  // stage 11: final correction and command select
  always_comb begin
    r_red = (r >= (RB+1)'(p)) ? r - (RB+1)'(p) : r;
    unique case (cmd_q[10])
      mfa_pkg::CMD_MUL,
      mfa_pkg::CMD_SQR: z_next = r_red[FB-1:0];
      default:          z_next = lin_q[10];
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      z <= z_next;
    end
  end

  assign z_lo  = z[63:0];
  assign z_mid = z[127:64];
  assign z_hi  = z[130:128];

endmodule

/* src/mfa_mul.sv */
// ----------------------------------------------------------------------------
// mfa_mul
// Three-stage 160x160 multiplier: limb products, column sums, carry add.
// ----------------------------------------------------------------------------
module mfa_mul #(
  parameter bit LowOnly = 1'b0
) (
  input  logic                           clk,
  input  logic                           en,
  input  logic [mfa_pkg::RADIX_BITS-1:0] x,
  input  logic [mfa_pkg::RADIX_BITS-1:0] y,
  output logic [mfa_pkg::PROD_BITS-1:0]  prod
);

  localparam int NL      = mfa_pkg::NUM_LIMBS;
  localparam int LB      = mfa_pkg::LIMB_BITS;
  localparam int NCOL    = 2 * NL;
  localparam int COL_W   = 2 * LB - LB + 5;
  localparam int PACK_W  = NCOL * LB + 2 * LB;

  logic [2*LB-1:0]  pp [NL][NL];
  logic [COL_W-1:0] col_next [NCOL];
  logic [COL_W-1:0] col [NCOL];
  logic [PACK_W-1:0] even_w, odd_w, sum_w;

  // stage 1: limb products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NL; i++) begin
        for (int j = 0; j < NL; j++) begin
          if (LowOnly && (i + j >= NL)) begin
            pp[i][j] <= '0;
          end else begin
            pp[i][j] <= (2*LB)'(x[i*LB +: LB]) * (2*LB)'(y[j*LB +: LB]);
          end
        end
      end
    end
  end

  // stage 2: column sums of low and high halves
  always_comb begin
    for (int c = 0; c < NCOL; c++) begin
      col_next[c] = '0;
      for (int i = 0; i < NL; i++) begin
        for (int j = 0; j < NL; j++) begin
          if (i + j == c) col_next[c] = col_next[c] + COL_W'(pp[i][j][LB-1:0]);
          if (i + j + 1 == c) col_next[c] = col_next[c] + COL_W'(pp[i][j][2*LB-1:LB]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      col <= col_next;
    end
  end

  // stage 3: even and odd columns do not overlap, one carry add
  always_comb begin
    even_w = '0;
    odd_w  = '0;
    for (int n = 0; n < NL; n++) begin
      even_w[2*n*LB +: COL_W]      = col[2*n];
      odd_w[(2*n+1)*LB +: COL_W]   = col[2*n+1];
    end
    sum_w = even_w + odd_w;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= sum_w[mfa_pkg::PROD_BITS-1:0];
    end
  end

endmodule

/* src/mfa_checker.sv */
// ----------------------------------------------------------------------------
// mfa_checker
// Port-level checks on the field ALU, bound to the top level.
// ----------------------------------------------------------------------------
module mfa_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] z_lo,
  input logic [63:0] z_mid,
  input logic [2:0]  z_hi
);

  // a waiting result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(z_lo) && $stable(z_mid) && $stable(z_hi))
    else $error("result changed while waiting");

  // reset empties the pipeline
  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // input side stalls only behind a waiting result
  a_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output back-pressure");

  // input side open whenever the output moves
  a_flow: assert property (@(posedge clk) disable iff (rst)
    !out_valid || out_ready |-> in_ready)
    else $error("input blocked while output free");

endmodule

bind montgomery_field_alu_core mfa_checker u_mfa_checker (.*);

/* bench/montgomery_field_alu_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// montgomery_field_alu_checker
// Watches the configuration port and both streaming channels of the field
// ALU, keeps its own copy of the modulus and inverse, predicts each result
// and compares every output transfer field by field in arrival order.
// ----------------------------------------------------------------------------
module montgomery_field_alu_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [2:0]  cmd,
  input  logic [63:0] a_lo,
  input  logic [63:0] a_mid,
  input  logic [2:0]  a_hi,
  input  logic [63:0] b_lo,
  input  logic [63:0] b_mid,
  input  logic [2:0]  b_hi,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [63:0] z_lo,
  input  logic [63:0] z_mid,
  input  logic [2:0]  z_hi,
  output int          errors,
  output int          pending
);

  logic [130:0] modulus;
  logic [159:0] minv;
  logic [130:0] expected_z[$];

  // modular result of one command under the current modulus and inverse
  function automatic logic [130:0] field_result(input logic [2:0] op,
                                                input logic [130:0] a,
                                                input logic [130:0] b);
    logic [319:0] aw, bw, pw, kw, t, tl, m, u, z;
    aw = a;
    bw = b;
    pw = modulus;
    kw = minv;
    z  = '0;
    case (op)
      mfa_pkg::CMD_ADD: begin
        z = aw + bw;
        if (z >= pw) z = z - pw;
      end
      mfa_pkg::CMD_SUB: begin
        z = aw - bw;
        if (aw < bw) z = z + pw;
      end
      mfa_pkg::CMD_NEG: begin
        if (aw != 0) z = pw - aw;
      end
      mfa_pkg::CMD_MUL, mfa_pkg::CMD_SQR: begin
        if (op == mfa_pkg::CMD_SQR) bw = aw;
        t  = aw * bw;
        tl = {160'b0, t[159:0]};
        m  = tl * kw;
        m  = {160'b0, m[159:0]};
        u  = (m * pw) >> 160;
        z  = (t >> 160) + u + ((tl != 0) ? 320'd1 : 320'd0);
        if (z >= pw) z = z - pw;
      end
      default: z = '0;
    endcase
    return z[130:0];
  endfunction

  assign pending = expected_z.size();

  // register mirror, prediction on input transfers, comparison on output
  always @(posedge clk) begin
    logic [130:0] exp_z;
    if (rst) begin
      modulus <= '0;
      minv    <= '0;
      errors  <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          mfa_pkg::REG_MOD_LO:  modulus[63:0]    <= cfg_data;
          mfa_pkg::REG_MOD_MID: modulus[127:64]  <= cfg_data;
          mfa_pkg::REG_MOD_HI:  modulus[130:128] <= cfg_data[2:0];
          mfa_pkg::REG_INV_LO:  minv[63:0]       <= cfg_data;
          mfa_pkg::REG_INV_MID: minv[127:64]     <= cfg_data;
          mfa_pkg::REG_INV_HI:  minv[159:128]    <= cfg_data[31:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        expected_z.push_back(field_result(cmd, {a_hi, a_mid, a_lo}, {b_hi, b_mid, b_lo}));
      if (out_valid && out_ready) begin
        if (expected_z.size() == 0) begin
          if (errors < 10) $display("unexpected result transfer %h", {z_hi, z_mid, z_lo});
          errors <= errors + 1;
        end else begin
          exp_z = expected_z.pop_front();
          if (z_lo !== exp_z[63:0] || z_mid !== exp_z[127:64] || z_hi !== exp_z[130:128]) begin
            if (errors < 10)
              $display("result mismatch: expected hi %h mid %h lo %h, got hi %h mid %h lo %h",
                       exp_z[130:128], exp_z[127:64], exp_z[63:0], z_hi, z_mid, z_lo);
            errors <= errors + 1;
          end
        end
      end
    end
  end

endmodule

/* bench/montgomery_field_alu_core_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// montgomery_field_alu_core_test
// Drives the field ALU through several moduli (zero, all ones, random full
// and narrow, mismatched inverse) with directed and random commands under
// random idling on both channels; a checker instance predicts and compares.
// ----------------------------------------------------------------------------
module montgomery_field_alu_core_test;

  localparam logic [2:0] CMD_RSVD_FIRST = mfa_pkg::CMD_SQR + 3'd1;
  localparam logic [2:0] CMD_RSVD_LAST  = 3'd7;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  cmd;
  logic [63:0] a_lo, a_mid, b_lo, b_mid;
  logic [2:0]  a_hi, b_hi;
  logic        out_valid;
  logic        out_ready;
  logic [63:0] z_lo, z_mid;
  logic [2:0]  z_hi;
  int          errors;
  int          pending;
  bit          calm;
  logic [130:0] field_p;

  montgomery_field_alu_core u_top (.*);

  montgomery_field_alu_checker u_checker (.*);

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // run limit
  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // result side back-pressure
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready <= calm || ($urandom_range(99) >= 30);
    end
  end

  // k = -p^-1 mod 2^160 by Newton iteration, p odd
  function automatic logic [159:0] neg_inverse(input logic [130:0] p);
    logic [159:0] x, pw;
    pw = p;
    x  = pw;
    repeat (6) x = x * (160'd2 - pw * x);
    return -x;
  endfunction

  function automatic logic [130:0] rand_wide();
    return {3'($urandom_range(7)), $urandom, $urandom, $urandom, $urandom};
  endfunction

  // operand mostly below p, sometimes at the edges or out of range
  function automatic logic [130:0] rand_operand();
    int sel;
    sel = $urandom_range(99);
    if (field_p == 0 || sel < 5) return rand_wide();
    if (sel < 8) return '0;
    if (sel < 11) return field_p - 1;
    if (sel < 13) return field_p;
    if (sel < 15) return '1;
    return rand_wide() % field_p;
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  task automatic load_field(input logic [130:0] p, input logic [159:0] k);
    field_p = p;
    write_reg(mfa_pkg::REG_MOD_LO, p[63:0]);
    write_reg(mfa_pkg::REG_MOD_MID, p[127:64]);
    write_reg(mfa_pkg::REG_MOD_HI, {61'b0, p[130:128]});
    write_reg(mfa_pkg::REG_INV_LO, k[63:0]);
    write_reg(mfa_pkg::REG_INV_MID, k[127:64]);
    write_reg(mfa_pkg::REG_INV_HI, {32'b0, k[159:128]});
  endtask

  // one transfer on the command channel, called and returning at a falling edge
  task automatic send(input logic [2:0] op, input logic [130:0] a, input logic [130:0] b);
    if (!calm && $urandom_range(99) < 30) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < 30);
    end
    in_valid <= 1'b1;
    cmd      <= op;
    {a_hi, a_mid, a_lo} <= a;
    {b_hi, b_mid, b_lo} <= b;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // wait until every result is back and the pipeline has emptied
  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (16) @(negedge clk);
  endtask

  task automatic directed_set();
    for (int c = mfa_pkg::CMD_ADD; c <= mfa_pkg::CMD_SQR; c++) begin
      send(3'(c), '0, '0);
      send(3'(c), field_p - 1, field_p - 1);
      send(3'(c), '1, '1);
    end
    send(mfa_pkg::CMD_SUB, 131'd1, 131'd2);
    send(mfa_pkg::CMD_NEG, 131'd1, '0);
    send(mfa_pkg::CMD_MUL, 131'd1, field_p - 1);
    for (int c = CMD_RSVD_FIRST; c <= CMD_RSVD_LAST; c++)
      send(3'(c), '1, '1);
  endtask

  task automatic random_phase(input int count);
    logic [2:0] op;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(19) == 0) op = 3'($urandom_range(CMD_RSVD_LAST, CMD_RSVD_FIRST));
      else op = 3'($urandom_range(mfa_pkg::CMD_SQR, mfa_pkg::CMD_ADD));
      send(op, rand_operand(), rand_operand());
      // hold off once until everything in flight has come back
      if (i == count / 2) begin
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
      end
    end
  endtask

  // stimulus and verdict
  initial begin
    logic [130:0] p;
    int width;
    rst       = 1'b1;
    calm      = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    cmd       = mfa_pkg::CMD_ADD;
    {a_hi, a_mid, a_lo} = '0;
    {b_hi, b_mid, b_lo} = '0;
    field_p   = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // zero modulus straight after reset
    directed_set();
    drain();

    // largest modulus, all ones
    p = '1;
    load_field(p, neg_inverse(p));
    directed_set();
    random_phase(200);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      width = (ph % 2 == 0) ? mfa_pkg::FIELD_BITS : $urandom_range(mfa_pkg::FIELD_BITS, 16);
      p = rand_wide() >> (mfa_pkg::FIELD_BITS - width);
      p[width-1] = 1'b1;
      p[0] = 1'b1;
      calm = (ph == 2);
      if (ph == 4) load_field(p, {$urandom, $urandom, $urandom, $urandom, $urandom});
      else if (ph == 5) begin
        p[0] = 1'b0;
        load_field(p, '1);
      end else load_field(p, neg_inverse(p));
      random_phase(200);
      drain();
    end
    calm = 1'b0;

    // back to the zero modulus
    load_field('0, '0);
    random_phase(20);
    drain();

    if (errors == 0 && pending == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

/* montgomery_field_alu_core.f */
src/mfa_pkg.sv
src/mfa_mul.sv
src/montgomery_field_alu_core.sv
src/mfa_checker.sv
bench/montgomery_field_alu_checker.sv
bench/montgomery_field_alu_core_test.sv
